// ===== design/ffd_pkg.sv =====
// Shared types, constants and helper functions for the fixed-frame deframer.
// No dependencies; used by every module of the block.
`default_nettype none

package ffd_pkg;

  // Frame layout: header x2, mode, id, payload bytes, CRC byte.
  localparam int unsigned EXTRA_BYTES = 8;
  localparam int unsigned STORE_DEPTH = 2 + EXTRA_BYTES;
  localparam int unsigned CRC_POS     = 4 + EXTRA_BYTES;
  localparam int unsigned POS_W       = $clog2(CRC_POS + 1);

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned APB_AW    = 4;
  localparam int unsigned APB_DW    = 32;

  localparam logic [POS_W-1:0] POS_HUNT1 = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HUNT2 = POS_W'(1);
  localparam logic [POS_W-1:0] POS_BODY  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CRC   = POS_W'(CRC_POS);

  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [7:0] HEADER_FIRST_RST  = 8'hA5;
  localparam logic [7:0] HEADER_SECOND_RST = 8'h5A;
  localparam logic [7:0] MIN_ID_RST        = 8'h01;
  localparam logic [7:0] MAX_ID_RST        = 8'h07;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_CRC    = 2'd1,
    ST_BAD_ID = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_HEADER_FIRST  = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_MIN_ID        = 2'd2,
    REG_MAX_ID        = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] min_id;
    logic [7:0] max_id;
  } cfg_t;

  // Reflected CRC-8, one byte, shift right.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Increment, holding at all ones.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== design/ffd_apb_regs.sv =====
// APB-style configuration registers: sync bytes and id bounds.
// Depends on ffd_pkg.
`default_nettype none

module ffd_apb_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ffd_pkg::APB_AW-1:0] paddr,
  input  wire logic [ffd_pkg::APB_DW-1:0] pwdata,
  output logic      [ffd_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output ffd_pkg::cfg_t                   cfg_o
);

  ffd_pkg::cfg_t     cfg_q;
  ffd_pkg::cfg_t     cfg_d;
  ffd_pkg::reg_idx_e idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = ffd_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        ffd_pkg::REG_HEADER_FIRST:  cfg_d.header_first  = pwdata[7:0];
        ffd_pkg::REG_HEADER_SECOND: cfg_d.header_second = pwdata[7:0];
        ffd_pkg::REG_MIN_ID:        cfg_d.min_id        = pwdata[7:0];
        ffd_pkg::REG_MAX_ID:        cfg_d.max_id        = pwdata[7:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ffd_pkg::REG_HEADER_FIRST:  prdata = ffd_pkg::APB_DW'(cfg_q.header_first);
      ffd_pkg::REG_HEADER_SECOND: prdata = ffd_pkg::APB_DW'(cfg_q.header_second);
      ffd_pkg::REG_MIN_ID:        prdata = ffd_pkg::APB_DW'(cfg_q.min_id);
      ffd_pkg::REG_MAX_ID:        prdata = ffd_pkg::APB_DW'(cfg_q.max_id);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first  <= ffd_pkg::HEADER_FIRST_RST;
      cfg_q.header_second <= ffd_pkg::HEADER_SECOND_RST;
      cfg_q.min_id        <= ffd_pkg::MIN_ID_RST;
      cfg_q.max_id        <= ffd_pkg::MAX_ID_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== design/ffd_deframer.sv =====
// Deframing datapath: input register, header hunt, byte position, CRC,
// frame store, saturating counters and result register.
// Depends on ffd_pkg.
`default_nettype none

module ffd_deframer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ffd_pkg::cfg_t                 cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    rx_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         frame_status_o,
  output logic [7:0]                         frame_mode_o,
  output logic [7:0]                         frame_id_o,
  output logic [ffd_pkg::PAYLOAD_W-1:0]      payload_o,
  output logic [ffd_pkg::CNT_W-1:0]          good_frames_o,
  output logic [ffd_pkg::CNT_W-1:0]          crc_errors_o,
  output logic [ffd_pkg::CNT_W-1:0]          bad_id_frames_o
);

  // Input register
  logic                     in_valid_q;
  logic [7:0]               in_byte_q;

  // Frame state
  logic [ffd_pkg::POS_W-1:0] pos_q, pos_d;
  logic [7:0]                crc_q, crc_d;
  logic [7:0]                store_q [ffd_pkg::STORE_DEPTH];
  logic                      store_we;

  logic [ffd_pkg::CNT_W-1:0] good_q, good_d;
  logic [ffd_pkg::CNT_W-1:0] crc_err_q, crc_err_d;
  logic [ffd_pkg::CNT_W-1:0] bad_id_q, bad_id_d;

  // Result register
  logic                           out_valid_q;
  ffd_pkg::status_e               status_q, status_d;
  logic [7:0]                     mode_q;
  logic [7:0]                     id_q;
  logic [ffd_pkg::PAYLOAD_W-1:0]  payload_q, payload_d;

  logic is_last;
  logic out_free;
  logic advance;
  logic fire;
  logic id_ok;
  logic crc_ok;

  assign is_last  = (pos_q == ffd_pkg::POS_CRC);
  assign out_free = !out_valid_q || !out_stall_i;
  // Bytes that close no frame never wait on the result side.
  assign advance  = in_valid_q && (!is_last || out_free);
  assign fire     = advance && is_last;

  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  assign crc_ok = (in_byte_q == crc_q);
  assign id_ok  = (store_q[1] >= cfg_i.min_id) && (store_q[1] <= cfg_i.max_id);

  // Position and CRC update
  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    store_we = 1'b0;
    if (advance) begin
      if (pos_q == ffd_pkg::POS_HUNT1) begin
        if (in_byte_q == cfg_i.header_first) begin
          crc_d = ffd_pkg::crc8_step(ffd_pkg::CRC_INIT, in_byte_q);
          pos_d = ffd_pkg::POS_HUNT2;
        end
      end else if (pos_q == ffd_pkg::POS_HUNT2) begin
        if (in_byte_q == cfg_i.header_second) begin
          crc_d = ffd_pkg::crc8_step(crc_q, in_byte_q);
          pos_d = ffd_pkg::POS_BODY;
        end else if (in_byte_q == cfg_i.header_first) begin
          // Repeated first sync byte: restart the CRC, stay put.
          crc_d = ffd_pkg::crc8_step(ffd_pkg::CRC_INIT, in_byte_q);
        end else begin
          pos_d = ffd_pkg::POS_HUNT1;
        end
      end else if (pos_q < ffd_pkg::POS_CRC) begin
        store_we = 1'b1;
        crc_d    = ffd_pkg::crc8_step(crc_q, in_byte_q);
        pos_d    = pos_q + ffd_pkg::POS_W'(1);
      end else begin
        pos_d = ffd_pkg::POS_HUNT1;
        crc_d = ffd_pkg::CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= ffd_pkg::POS_HUNT1;
      crc_q <= ffd_pkg::CRC_INIT;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < int'(ffd_pkg::STORE_DEPTH); k++) begin
      if (store_we && (pos_q == ffd_pkg::POS_W'(k + 2))) begin
        store_q[k] <= in_byte_q;
      end
    end
  end

  // Status and counters
  always_comb begin
    good_d    = good_q;
    crc_err_d = crc_err_q;
    bad_id_d  = bad_id_q;
    if (!crc_ok) begin
      status_d  = ffd_pkg::ST_CRC;
      crc_err_d = ffd_pkg::sat_inc(crc_err_q);
    end else if (id_ok) begin
      status_d = ffd_pkg::ST_OK;
      good_d   = ffd_pkg::sat_inc(good_q);
    end else begin
      status_d = ffd_pkg::ST_BAD_ID;
      bad_id_d = ffd_pkg::sat_inc(bad_id_q);
    end
  end

  always_comb begin
    payload_d = '0;
    for (int l = 0; l < 8; l++) begin
      if (l < int'(ffd_pkg::EXTRA_BYTES)) begin
        payload_d[8*l +: 8] = store_q[2 + l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_q      <= '0;
      crc_err_q   <= '0;
      bad_id_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        good_q    <= good_d;
        crc_err_q <= crc_err_d;
        bad_id_q  <= bad_id_d;
      end
      out_valid_q <= fire || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q  <= status_d;
      mode_q    <= store_q[0];
      id_q      <= store_q[1];
      payload_q <= payload_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_status_o  = status_q;
  assign frame_mode_o    = mode_q;
  assign frame_id_o      = id_q;
  assign payload_o       = payload_q;
  assign good_frames_o   = good_q;
  assign crc_errors_o    = crc_err_q;
  assign bad_id_frames_o = bad_id_q;

endmodule

`default_nettype wire

// ===== design/fixed_frame_deframer_crc8_top.sv =====
// Top level of the fixed-length frame deframer with CRC-8 check.
// Depends on ffd_pkg, ffd_apb_regs and ffd_deframer.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+-------------------------------------
//   rx in     | in_valid_i / in_stall_o    | rx_byte_i
//   result out| out_valid_o / out_stall_i  | frame_status_o .. bad_id_frames_o
//   config    | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One byte beat is taken every cycle while in_stall_o is low: the beat is held
// in the input register, then a single pass (hunt compare, one CRC-8 byte step,
// store write or CRC and id compare plus saturating increment) lands in the
// state and result registers. Only the CRC byte of a frame needs the result
// register free, so a stalled result holds back input only when the next beat
// closes another frame. Reset returns to the hunt for the first sync byte, CRC
// at 0xFF, counters cleared and registers at their defaults.
`default_nettype none

module fixed_frame_deframer_crc8_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ffd_pkg::APB_AW-1:0]    paddr,
  input  wire logic [ffd_pkg::APB_DW-1:0]    pwdata,
  output logic      [ffd_pkg::APB_DW-1:0]    prdata,
  output logic                               pready,
  // Byte input
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    rx_byte_i,
  // Frame results
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         frame_status_o,
  output logic [7:0]                         frame_mode_o,
  output logic [7:0]                         frame_id_o,
  output logic [ffd_pkg::PAYLOAD_W-1:0]      payload_o,
  output logic [ffd_pkg::CNT_W-1:0]          good_frames_o,
  output logic [ffd_pkg::CNT_W-1:0]          crc_errors_o,
  output logic [ffd_pkg::CNT_W-1:0]          bad_id_frames_o
);

  // Live register values; the user must write them only while the datapath is idle, the block does not enforce it.
  ffd_pkg::cfg_t cfg;

  ffd_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Hunt, gather, check and count.
  ffd_deframer u_deframer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_status_o  (frame_status_o),
    .frame_mode_o    (frame_mode_o),
    .frame_id_o      (frame_id_o),
    .payload_o       (payload_o),
    .good_frames_o   (good_frames_o),
    .crc_errors_o    (crc_errors_o),
    .bad_id_frames_o (bad_id_frames_o)
  );

endmodule

`default_nettype wire
